// ===== rtl/follow_mission_mode_controller_macros.svh =====
// ----------------------------------------------------------------------------
// follow mission mode controller assertion macros
// concurrent assertion wrappers, empty when synthesizing
// ----------------------------------------------------------------------------
`ifndef FOLLOW_MISSION_MODE_CONTROLLER_MACROS_SVH
`define FOLLOW_MISSION_MODE_CONTROLLER_MACROS_SVH

`ifndef SYNTHESIS
// checked only out of reset
`define FMMC_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("fmmc assertion failed");
// checked at every edge, reset included
`define FMMC_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("fmmc assertion failed");
`else
`define FMMC_ASSERT(label, clk, rst_n, prop)
`define FMMC_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

// ===== rtl/fmmc_pkg.sv =====
// ----------------------------------------------------------------------------
// fmmc_pkg
// types and codes shared by the follow mission mode controller
// ----------------------------------------------------------------------------
package fmmc_pkg;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_EXEC = 2'd1,
        ST_DONE = 2'd2,
        ST_QUIT = 2'd3
    } mission_state_t;

    // command codes, codes four to seven carry no command
    localparam logic [2:0] CMD_STOP     = 3'd0;
    localparam logic [2:0] CMD_RUN      = 3'd1;
    localparam logic [2:0] CMD_PAUSE    = 3'd2;
    localparam logic [2:0] CMD_COMPLETE = 3'd3;

    localparam logic [1:0] DRIVE_MANUAL     = 2'd0;
    localparam logic [1:0] DRIVE_AUTONOMOUS = 2'd1;

    localparam logic [1:0] TASK_IDLE   = 2'd0;
    localparam logic [1:0] TASK_RUN    = 2'd1;
    localparam logic [1:0] TASK_PAUSED = 2'd2;
    localparam logic [1:0] TASK_ENDED  = 2'd3;

    localparam int          CountW       = 4;
    localparam logic [3:0]  CountMax     = 4'd15;
    localparam logic [3:0]  ConfirmReset = 4'd3;

    // configuration register map
    localparam int          AddrW             = 3;
    localparam logic [2:0]  ADDR_CONFIRM_FRAMES = 3'd0;

    // km/h conversion: (v * 36 + 5) / 10, divide by reciprocal
    localparam int          SpeedW    = 16;
    localparam int          KmhW      = 18;
    localparam int          ScaledW   = 22;
    localparam int          RecipW    = 23;
    localparam int          RecipSh   = 26;
    localparam logic [22:0] Recip10   = 23'd6710887;

    typedef struct packed {
        logic [15:0] speed_limit_in;
        logic        emergency_stop_in;
        logic [2:0]  command;
        logic [1:0]  drive_mode;
    } fmmc_in_t;

    typedef struct packed {
        logic [17:0] speed_limit_kmh;
        logic        emergency_stop_out;
        logic [1:0]  task_status_out;
        logic [1:0]  mission_phase;
    } fmmc_out_t;

    typedef struct packed {
        logic [1:0] mission_phase;
        logic [1:0] task_status_out;
        logic       emergency_stop_out;
    } fmmc_mode_res_t;

endpackage

// ===== rtl/fmmc_cfg.sv =====
// ----------------------------------------------------------------------------
// fmmc_cfg
// apb register file holding the confirm frame count
// ----------------------------------------------------------------------------
module fmmc_cfg import fmmc_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [AddrW-1:0] paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    output logic [CountW-1:0] confirm_frames
);

    logic [CountW-1:0] confirm_reg;
    logic [CountW-1:0] confirm_next;
    logic              wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr == ADDR_CONFIRM_FRAMES);

    always_comb begin
        confirm_next = confirm_reg;
        if (wr_en) begin
            confirm_next = pwdata[CountW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            confirm_reg <= ConfirmReset;
        end else begin
            confirm_reg <= confirm_next;
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr == ADDR_CONFIRM_FRAMES) begin
            prdata = {{(32-CountW){1'b0}}, confirm_reg};
        end
    end

    assign confirm_frames = confirm_reg;

endmodule

// ===== rtl/fmmc_speed.sv =====
// ----------------------------------------------------------------------------
// fmmc_speed
// m/s to km/h conversion of a q8.8 speed limit, rounded half up
// ----------------------------------------------------------------------------
module fmmc_speed import fmmc_pkg::*; (
    input  logic [SpeedW-1:0] speed_limit_in,
    output logic [KmhW-1:0]   speed_limit_kmh
);

    logic [ScaledW-1:0]        scaled;
    logic [ScaledW+RecipW-1:0] prod;

    // v * 36 as two shifted terms, plus the constant 5
    assign scaled = {1'b0, speed_limit_in, 5'b0}
                  + {4'b0, speed_limit_in, 2'b0}
                  + ScaledW'(5);

    // exact floor divide by ten for every 22 bit value
    assign prod = {{RecipW{1'b0}}, scaled} * {{ScaledW{1'b0}}, Recip10};

    assign speed_limit_kmh = prod[RecipSh+KmhW-1:RecipSh];

endmodule

// ===== rtl/fmmc_mode.sv =====
// ----------------------------------------------------------------------------
// fmmc_mode
// mission state machine with quit sequencing and start/pause debounce
// ----------------------------------------------------------------------------
`include "follow_mission_mode_controller_macros.svh"

module fmmc_mode import fmmc_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step,
    input  fmmc_in_t          item,
    input  logic [CountW-1:0] confirm_frames,
    output fmmc_mode_res_t    res
);

    mission_state_t    state_reg,        state_next;
    logic              quit_pending_reg, quit_pending_next;
    logic              prev_auto_reg,    prev_auto_next;
    logic [CountW-1:0] start_count_reg,  start_count_next;
    logic [CountW-1:0] pause_count_reg,  pause_count_next;
    logic              paused_reg,       paused_next;
    logic [CountW-1:0] start_bump;
    logic [CountW-1:0] pause_bump;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            quit_pending_reg <= 1'b0;
            prev_auto_reg    <= 1'b0;
            start_count_reg  <= '0;
            pause_count_reg  <= '0;
            paused_reg       <= 1'b0;
        end else if (step) begin
            state_reg        <= state_next;
            quit_pending_reg <= quit_pending_next;
            prev_auto_reg    <= prev_auto_next;
            start_count_reg  <= start_count_next;
            pause_count_reg  <= pause_count_next;
            paused_reg       <= paused_next;
        end
    end

    assign start_bump = (start_count_reg == CountMax) ? CountMax : start_count_reg + 1'b1;
    assign pause_bump = (pause_count_reg == CountMax) ? CountMax : pause_count_reg + 1'b1;

    always_comb begin
        state_next        = state_reg;
        quit_pending_next = quit_pending_reg;
        start_count_next  = start_count_reg;
        pause_count_next  = pause_count_reg;
        paused_next       = paused_reg;
        prev_auto_next    = (item.drive_mode == DRIVE_AUTONOMOUS);

        if (quit_pending_reg) begin
            state_next        = ST_IDLE;
            quit_pending_next = 1'b0;
        end else if (prev_auto_reg && (item.drive_mode == DRIVE_MANUAL)) begin
            state_next        = ST_QUIT;
            quit_pending_next = 1'b1;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    start_count_next = '0;
                    pause_count_next = '0;
                    if (item.command == CMD_RUN) begin
                        if (start_bump >= confirm_frames) begin
                            state_next  = ST_EXEC;
                            paused_next = 1'b0;
                        end else begin
                            start_count_next = start_bump;
                        end
                    end else if (item.command == CMD_PAUSE) begin
                        if (pause_bump >= confirm_frames) begin
                            state_next  = ST_EXEC;
                            paused_next = 1'b1;
                        end else begin
                            pause_count_next = pause_bump;
                        end
                    end
                end
                ST_EXEC: begin
                    case (item.command)
                        CMD_STOP:     state_next  = ST_IDLE;
                        CMD_RUN:      paused_next = 1'b0;
                        CMD_PAUSE:    paused_next = 1'b1;
                        CMD_COMPLETE: state_next  = ST_DONE;
                        default:      state_next  = state_reg;
                    endcase
                end
                ST_DONE: begin
                    case (item.command)
                        CMD_STOP: state_next = ST_IDLE;
                        CMD_RUN:  state_next = ST_EXEC;
                        default:  state_next = state_reg;
                    endcase
                end
                ST_QUIT: begin
                    state_next = state_reg;
                end
                default: begin
                    state_next = state_reg;
                end
            endcase
        end

        // result follows the updated state
        res.mission_phase = state_next;
        unique case (state_next)
            ST_DONE: begin
                res.task_status_out    = TASK_ENDED;
                res.emergency_stop_out = 1'b1;
            end
            ST_EXEC: begin
                res.task_status_out    = paused_next ? TASK_PAUSED : TASK_RUN;
                res.emergency_stop_out = item.emergency_stop_in;
            end
            ST_QUIT: begin
                res.task_status_out    = TASK_ENDED;
                res.emergency_stop_out = 1'b0;
            end
            default: begin
                res.task_status_out    = TASK_IDLE;
                res.emergency_stop_out = 1'b0;
            end
        endcase
    end

    `FMMC_ASSERT(a_quit_matches_pending, aclk, aresetn, (state_reg == ST_QUIT) == quit_pending_reg)
    `FMMC_ASSERT(a_counts_exclusive, aclk, aresetn, (start_count_reg == '0) || (pause_count_reg == '0))
    `FMMC_ASSERT(a_quit_releases, aclk, aresetn, step && quit_pending_reg |=> (state_reg == ST_IDLE) && !quit_pending_reg)

endmodule

// ===== rtl/follow_mission_mode_controller.sv =====
// an accepted item passes the input register, then the result register, to m_tvalid
// throughput: one item per cycle, sustained while m_tready stays high
// the input register holds its item while the result register waits on m_tready
// reset: aresetn synchronous active low; mission idle, counters and flags zero,
// confirm_frames back to 3, both pipeline stages empty
// ----------------------------------------------------------------------------
// follow_mission_mode_controller
// follow mission mode control with quit sequencing and speed conversion
// ----------------------------------------------------------------------------
`include "follow_mission_mode_controller_macros.svh"

module follow_mission_mode_controller import fmmc_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    // apb configuration
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [AddrW-1:0] paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    // input item
    input  logic             s_tvalid,
    output logic             s_tready,
    // drive_mode[1:0], command[4:2], emergency_stop_in[5], speed_limit_in[21:6]
    input  logic [23:0]      s_tdata,
    // result item
    output logic             m_tvalid,
    input  logic             m_tready,
    // mission_phase[1:0], task_status_out[3:2], emergency_stop_out[4],
    // speed_limit_kmh[22:5]
    output logic [23:0]      m_tdata
);

    logic              in_valid_reg,  in_valid_next;
    fmmc_in_t          in_item_reg,   in_item_next;
    logic              out_valid_reg, out_valid_next;
    fmmc_out_t         out_item_reg,  out_item_next;
    logic              advance;
    logic              in_fire;
    logic [CountW-1:0] confirm_frames;
    fmmc_mode_res_t    mode_res;
    logic [KmhW-1:0]   kmh;

    fmmc_cfg u_cfg (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .confirm_frames (confirm_frames)
    );

    fmmc_mode u_mode (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .step           (advance),
        .item           (in_item_reg),
        .confirm_frames (confirm_frames),
        .res            (mode_res)
    );

    fmmc_speed u_speed (
        .speed_limit_in  (in_item_reg.speed_limit_in),
        .speed_limit_kmh (kmh)
    );

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign in_fire  = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        in_item_next  = in_item_reg;
        if (in_fire) begin
            in_valid_next = 1'b1;
            in_item_next  = s_tdata[$bits(fmmc_in_t)-1:0];
        end else if (advance) begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;
        if (advance) begin
            out_valid_next                   = 1'b1;
            out_item_next.mission_phase      = mode_res.mission_phase;
            out_item_next.task_status_out    = mode_res.task_status_out;
            out_item_next.emergency_stop_out = mode_res.emergency_stop_out;
            out_item_next.speed_limit_kmh    = kmh;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_item_reg  <= in_item_next;
        out_item_reg <= out_item_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(24-$bits(fmmc_out_t)){1'b0}}, out_item_reg};

    `FMMC_ASSERT_ALWAYS(a_reset_empties, aclk, !aresetn |=> !out_valid_reg && !in_valid_reg)
    `FMMC_ASSERT(a_empty_out_fills, aclk, aresetn, in_valid_reg && !out_valid_reg |=> out_valid_reg)
    `FMMC_ASSERT(a_ready_when_drained, aclk, aresetn, !out_valid_reg |-> s_tready)

endmodule
